### rtl/heat_ftcs_stencil_pass_core_macros.svh
// Assertion macros shared by the stencil pass RTL.
// Included by files that carry concurrent assertions; depends on nothing else.
`ifndef HEAT_FTCS_STENCIL_PASS_CORE_MACROS_SVH
`define HEAT_FTCS_STENCIL_PASS_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HFSP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stencil pass: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define HFSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stencil pass: next-cycle check failed");

`endif

### rtl/hfsp_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths, register codes and reset values of the stencil pass.
// No dependencies; every other RTL file of the block imports it.
package hfsp_pkg;

    localparam int TEMP_W    = 32;
    localparam int COEF_W    = 32;
    localparam int IDX_W     = 6;
    localparam int CFG_IDX_W = 3;
    localparam int HALF_W    = 16;

    // Arithmetic widths of the update datapath.
    localparam int DIFF_W = TEMP_W + 2;
    localparam int PROD_W = HALF_W + 1 + DIFF_W;
    localparam int GAIN_W = DIFF_W + 2;
    localparam int SUM_W  = TEMP_W + 6;

    localparam int DEFAULT_MAX_COLS = 64;

    // Result queue between the update pipeline and the output port.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_LAST  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_LAST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOT_ROW_LO = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOT_ROW_HI = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HOT_COL_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HOT_COL_HI = 3'd7;

    // Reset values of the configuration registers.
    localparam logic [COEF_W-1:0] COEF_RESET      = 32'd1133000;
    localparam logic [IDX_W-1:0]  SIZE_RESET      = 6'd50;
    localparam logic [IDX_W-1:0]  HOT_LO_RESET    = 6'd24;
    localparam logic [IDX_W-1:0]  HOT_HI_RESET    = 6'd26;

    typedef logic signed [TEMP_W-1:0] temp_t;
    typedef logic [IDX_W-1:0]         idx_t;

    // Line store access for one cycle: the write of the accepted cell and the
    // read of the neighbors of the next cell.
    typedef struct packed {
        logic we;
        logic wpar;
        idx_t wcol;
        logic rd_par;
        idx_t rd_col;
    } store_req_t;

    // Control that travels with a cell through the update pipeline.
    typedef struct packed {
        logic  above_vld;
        logic  calc;
        logic  self_vld;
        logic  self_last;
        idx_t  row;
        idx_t  col;
        temp_t self_temp;
    } tag_t;

    // Up to two results caused by one input cell, in emission order.
    typedef struct packed {
        logic  above_vld;
        logic  self_vld;
        logic  self_last;
        idx_t  row;
        idx_t  col;
        temp_t above_temp;
        temp_t self_temp;
    } pair_t;

endpackage

### rtl/heat_ftcs_stencil_pass_core.sv
`timescale 1ns / 1ps
`include "heat_ftcs_stencil_pass_core_macros.svh"
// Top level of the FTCS five-point heat stencil pass over a raster-order grid.
// Depends on hfsp_pkg, hfsp_line_store, hfsp_update_pipe and the assertion macros.
//
// Channel  Dir  Handshake              Payload
// cfg      in   cfg_valid / cfg_ready  cfg_index, cfg_data
// in       in   in_valid / in_stall    temp_in
// out      out  out_valid / out_stall  temp_out, row_index, col_index, grid_last
//
// One input cell is taken every cycle while not stalled; a cell of the last row
// can cause two results and so occupies the output for two transfers. The line store
// read port and the forwarding of a same-cycle write set the one-cell-per-cycle pace,
// and the four-stage update pipeline feeds the result queue in front of the output.
// Reset clears the counters, the window register and the queue and restores the reset
// configuration; the line store is not cleared, it is written before it is read.
// in_stall rises only when the eight-entry queue has no room for the cells in flight.
module heat_ftcs_stencil_pass_core #(
    parameter int MAX_COLS = hfsp_pkg::DEFAULT_MAX_COLS
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hfsp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hfsp_pkg::COEF_W-1:0]    cfg_data,

    input  logic                           in_valid,
    output logic                           in_stall,
    input  hfsp_pkg::temp_t                temp_in,

    output logic                           out_valid,
    input  logic                           out_stall,
    output hfsp_pkg::temp_t                temp_out,
    output hfsp_pkg::idx_t                 row_index,
    output hfsp_pkg::idx_t                 col_index,
    output logic                           grid_last
);
    import hfsp_pkg::*;

    // Configuration registers.
    logic [COEF_W-1:0] coef_x_reg, coef_y_reg;
    idx_t              rows_last_reg, cols_last_reg;
    idx_t              hot_row_lo_reg, hot_row_hi_reg, hot_col_lo_reg, hot_col_hi_reg;

    // Raster position of the next input cell.
    idx_t              row_count_reg, row_count_next;
    idx_t              col_count_reg, col_count_next;

    // Center of the previous transfer, which is the left neighbor of this one.
    temp_t             left_reg, left_next;

    logic              in_xfer;
    logic              col_end, row_end;
    logic              has_above;
    idx_t              above_row;
    logic              in_window;
    logic              calc;
    store_req_t        store_req;
    temp_t             center, right, up;
    tag_t              tag;

    logic              pipe_vld;
    pair_t             pipe_pair;

    // Result queue, one entry per input cell that causes any result.
    pair_t             fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  fifo_cnt_reg, fifo_cnt_next;
    logic [CNT_W-1:0]  credit_reg, credit_next;
    logic              phase_reg, phase_next;

    logic              push, drop, pop;
    logic              out_xfer;
    logic              show_above;
    pair_t             head;

    //------------------------------------------------------------------------
    // Configuration port. Writes are always taken; an index without a
    // register behind it is ignored.
    //------------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_x_reg     <= COEF_RESET;
            coef_y_reg     <= COEF_RESET;
            rows_last_reg  <= SIZE_RESET;
            cols_last_reg  <= SIZE_RESET;
            hot_row_lo_reg <= HOT_LO_RESET;
            hot_row_hi_reg <= HOT_HI_RESET;
            hot_col_lo_reg <= HOT_LO_RESET;
            hot_col_hi_reg <= HOT_HI_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_COEF_X:     coef_x_reg     <= cfg_data;
                CFG_COEF_Y:     coef_y_reg     <= cfg_data;
                CFG_ROWS_LAST:  rows_last_reg  <= cfg_data[IDX_W-1:0];
                CFG_COLS_LAST:  cols_last_reg  <= cfg_data[IDX_W-1:0];
                CFG_HOT_ROW_LO: hot_row_lo_reg <= cfg_data[IDX_W-1:0];
                CFG_HOT_ROW_HI: hot_row_hi_reg <= cfg_data[IDX_W-1:0];
                CFG_HOT_COL_LO: hot_col_lo_reg <= cfg_data[IDX_W-1:0];
                CFG_HOT_COL_HI: hot_col_hi_reg <= cfg_data[IDX_W-1:0];
                default:        ;
            endcase
        end
    end

    //------------------------------------------------------------------------
    // Raster counters. A count at or beyond the last index ends its row or
    // the grid, so counts left over from a larger grid still wrap to zero.
    //------------------------------------------------------------------------
    assign in_stall = (credit_reg == CNT_W'(FIFO_DEPTH));
    assign in_xfer  = in_valid && !in_stall;

    assign col_end = (col_count_reg >= cols_last_reg);
    assign row_end = (row_count_reg >= rows_last_reg);

    always_comb
    begin
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        if (in_xfer)
        begin
            if (col_end)
            begin
                col_count_next = '0;
                row_count_next = row_end ? '0 : row_count_reg + IDX_W'(1);
            end
            else
            begin
                col_count_next = col_count_reg + IDX_W'(1);
            end
        end
    end

    //------------------------------------------------------------------------
    // Line store. Every cycle it reads the neighbors of the cell that will
    // be at the input after this edge, so the data is ready the cycle that
    // cell arrives even when it follows directly.
    //------------------------------------------------------------------------
    assign store_req = '{we:     in_xfer,
                         wpar:   row_count_reg[0],
                         wcol:   col_count_reg,
                         rd_par: row_count_next[0],
                         rd_col: col_count_next};

    hfsp_line_store #(
        .MAX_COLS (MAX_COLS)
    ) u_line_store (
        .clk     (clk),
        .req     (store_req),
        .wr_data (temp_in),
        .center  (center),
        .right   (right),
        .up      (up)
    );

    //------------------------------------------------------------------------
    // Classification of the arriving cell. The result for the cell above is
    // due now; it is updated only when that cell is interior and outside the
    // fixed-temperature window. An empty window has lo above hi.
    //------------------------------------------------------------------------
    assign has_above = (row_count_reg != '0);
    assign above_row = row_count_reg - IDX_W'(1);

    assign in_window = (above_row >= hot_row_lo_reg) && (above_row <= hot_row_hi_reg) &&
                       (col_count_reg >= hot_col_lo_reg) && (col_count_reg <= hot_col_hi_reg);

    assign calc = has_above && (above_row != '0) && (above_row < rows_last_reg) &&
                  (col_count_reg != '0) && (col_count_reg < cols_last_reg) && !in_window;

    assign tag = '{above_vld: has_above,
                   calc:      calc,
                   self_vld:  row_end,
                   self_last: col_end,
                   row:       row_count_reg,
                   col:       col_count_reg,
                   self_temp: temp_in};

    always_comb
    begin
        left_next = left_reg;
        if (in_xfer && has_above)
        begin
            left_next = center;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            col_count_reg <= '0;
            left_reg      <= '0;
        end
        else
        begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
            left_reg      <= left_next;
        end
    end

    hfsp_update_pipe u_update_pipe (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (in_xfer),
        .in_tag   (tag),
        .center   (center),
        .up       (up),
        .down     (temp_in),
        .left     (left_reg),
        .right    (right),
        .coef_x   (coef_x_reg),
        .coef_y   (coef_y_reg),
        .out_vld  (pipe_vld),
        .out_pair (pipe_pair)
    );

    //------------------------------------------------------------------------
    // Result queue and output. Each accepted cell holds one credit until its
    // entry leaves the queue, or until it reaches the queue with no result
    // at all. The queue therefore never overflows, and the pipeline never
    // has to stop. An entry with two results is sent in two transfers, the
    // cell above first.
    //------------------------------------------------------------------------
    assign push = pipe_vld && (pipe_pair.above_vld || pipe_pair.self_vld);
    assign drop = pipe_vld && !(pipe_pair.above_vld || pipe_pair.self_vld);

    assign head       = fifo_mem[rd_ptr_reg];
    assign out_valid  = (fifo_cnt_reg != '0);
    assign show_above = !phase_reg && head.above_vld;
    assign out_xfer   = out_valid && !out_stall;
    assign pop        = out_xfer && (!show_above || !head.self_vld);

    assign temp_out  = show_above ? head.above_temp : head.self_temp;
    assign row_index = show_above ? head.row - IDX_W'(1) : head.row;
    assign col_index = head.col;
    assign grid_last = !show_above && head.self_last;

    always_comb
    begin
        wr_ptr_next   = push ? wr_ptr_reg + FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next   = pop ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        fifo_cnt_next = fifo_cnt_reg + CNT_W'(push) - CNT_W'(pop);
        credit_next   = credit_reg + CNT_W'(in_xfer) - CNT_W'(pop) - CNT_W'(drop);
        phase_next    = phase_reg;
        if (pop)
        begin
            phase_next = 1'b0;
        end
        else if (out_xfer)
        begin
            phase_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= pipe_pair;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
            credit_reg   <= '0;
            phase_reg    <= 1'b0;
        end
        else
        begin
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            fifo_cnt_reg <= fifo_cnt_next;
            credit_reg   <= credit_next;
            phase_reg    <= phase_next;
        end
    end

    //------------------------------------------------------------------------
    // Checks.
    //------------------------------------------------------------------------
    `HFSP_ASSERT_IMPLY(a_queue_within_credit, clk, rst_n, 1'b1, fifo_cnt_reg <= credit_reg)
    `HFSP_ASSERT_IMPLY(a_push_has_room, clk, rst_n, push, fifo_cnt_reg < CNT_W'(FIFO_DEPTH))
    `HFSP_ASSERT_NEXT(a_pair_second_half, clk, rst_n,
                      out_xfer && show_above && head.self_vld, phase_reg && out_valid)

endmodule

### rtl/hfsp_line_store.sv
`timescale 1ns / 1ps
// Two-row line store of the stencil pass: one synchronous memory per row parity.
// Depends on hfsp_pkg.
module hfsp_line_store #(
    parameter int MAX_COLS = hfsp_pkg::DEFAULT_MAX_COLS
) (
    input  logic                  clk,
    input  hfsp_pkg::store_req_t  req,
    input  hfsp_pkg::temp_t       wr_data,
    output hfsp_pkg::temp_t       center,
    output hfsp_pkg::temp_t       right,
    output hfsp_pkg::temp_t       up
);
    import hfsp_pkg::*;

    localparam int COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int DEPTH  = 2 ** COL_AW;

    temp_t bank0_mem [DEPTH];
    temp_t bank1_mem [DEPTH];

    logic [COL_AW-1:0] wr_addr;
    logic [COL_AW-1:0] rd_addr_a;
    logic [COL_AW-1:0] rd_addr_b;

    temp_t rd0a_reg, rd0b_reg, rd1a_reg, rd1b_reg;
    temp_t fwd_data_reg;
    logic  hit0a_reg, hit0b_reg, hit1a_reg, hit1b_reg;
    logic  par_reg;

    temp_t b0a, b0b, b1a, b1b;

    // Port a reads the column of the next cell, port b the column after it.
    assign wr_addr   = COL_AW'(req.wcol);
    assign rd_addr_a = COL_AW'(req.rd_col);
    assign rd_addr_b = COL_AW'({1'b0, req.rd_col} + (IDX_W + 1)'(1));

    always_ff @(posedge clk)
    begin
        if (req.we && !req.wpar)
        begin
            bank0_mem[wr_addr] <= wr_data;
        end
        rd0a_reg <= bank0_mem[rd_addr_a];
        rd0b_reg <= bank0_mem[rd_addr_b];
    end

    always_ff @(posedge clk)
    begin
        if (req.we && req.wpar)
        begin
            bank1_mem[wr_addr] <= wr_data;
        end
        rd1a_reg <= bank1_mem[rd_addr_a];
        rd1b_reg <= bank1_mem[rd_addr_b];
    end

    // A write in the same cycle as a read of the same entry is forwarded.
    always_ff @(posedge clk)
    begin
        hit0a_reg    <= req.we && !req.wpar && (wr_addr == rd_addr_a);
        hit0b_reg    <= req.we && !req.wpar && (wr_addr == rd_addr_b);
        hit1a_reg    <= req.we && req.wpar && (wr_addr == rd_addr_a);
        hit1b_reg    <= req.we && req.wpar && (wr_addr == rd_addr_b);
        fwd_data_reg <= wr_data;
        par_reg      <= req.rd_par;
    end

    assign b0a = hit0a_reg ? fwd_data_reg : rd0a_reg;
    assign b0b = hit0b_reg ? fwd_data_reg : rd0b_reg;
    assign b1a = hit1a_reg ? fwd_data_reg : rd1a_reg;
    assign b1b = hit1b_reg ? fwd_data_reg : rd1b_reg;

    // The row above lives in the other bank; the bank of the cell's own row
    // still holds the row two above.
    assign center = par_reg ? b0a : b1a;
    assign right  = par_reg ? b0b : b1b;
    assign up     = par_reg ? b1a : b0a;

endmodule

### rtl/hfsp_update_pipe.sv
`timescale 1ns / 1ps
// Four-stage FTCS update datapath: differences, split products, gains, saturated sum.
// Depends on hfsp_pkg.
module hfsp_update_pipe (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_vld,
    input  hfsp_pkg::tag_t              in_tag,
    input  hfsp_pkg::temp_t             center,
    input  hfsp_pkg::temp_t             up,
    input  hfsp_pkg::temp_t             down,
    input  hfsp_pkg::temp_t             left,
    input  hfsp_pkg::temp_t             right,
    input  logic [hfsp_pkg::COEF_W-1:0] coef_x,
    input  logic [hfsp_pkg::COEF_W-1:0] coef_y,
    output logic                        out_vld,
    output hfsp_pkg::pair_t             out_pair
);
    import hfsp_pkg::*;

    logic signed [DIFF_W-1:0] dv, dh;
    logic signed [PROD_W-1:0] pxh, pxl, pyh, pyl;
    logic signed [PROD_W:0]   ax, ay;
    logic signed [GAIN_W-1:0] gx, gy;
    logic signed [SUM_W-1:0]  sum;
    temp_t                    sat;
    temp_t                    above_temp;

    logic                     s1_vld_reg, s2_vld_reg, s3_vld_reg, out_vld_reg;
    tag_t                     s1_tag_reg, s2_tag_reg, s3_tag_reg;
    temp_t                    s1_t_reg, s2_t_reg, s3_t_reg;
    logic signed [DIFF_W-1:0] s1_dv_reg, s1_dh_reg;
    logic signed [PROD_W-1:0] s2_pxh_reg, s2_pxl_reg, s2_pyh_reg, s2_pyl_reg;
    logic signed [GAIN_W-1:0] s3_gx_reg, s3_gy_reg;
    pair_t                    out_pair_reg;

    assign dv = DIFF_W'(up) + DIFF_W'(down) - (DIFF_W'(center) <<< 1);
    assign dh = DIFF_W'(left) + DIFF_W'(right) - (DIFF_W'(center) <<< 1);

    // Each 32-bit coefficient is split into halves so that no product is
    // wider than 17 by 34 bits.
    assign pxh = $signed({1'b0, coef_x[COEF_W-1:HALF_W]}) * s1_dv_reg;
    assign pxl = $signed({1'b0, coef_x[HALF_W-1:0]}) * s1_dv_reg;
    assign pyh = $signed({1'b0, coef_y[COEF_W-1:HALF_W]}) * s1_dh_reg;
    assign pyl = $signed({1'b0, coef_y[HALF_W-1:0]}) * s1_dh_reg;

    // Arithmetic shifts floor, so the two-step shift equals one floor by 2^32.
    assign ax = (PROD_W + 1)'(s2_pxh_reg) + (PROD_W + 1)'(s2_pxl_reg >>> HALF_W);
    assign ay = (PROD_W + 1)'(s2_pyh_reg) + (PROD_W + 1)'(s2_pyl_reg >>> HALF_W);
    assign gx = GAIN_W'(ax >>> HALF_W);
    assign gy = GAIN_W'(ay >>> HALF_W);

    assign sum = SUM_W'(s3_t_reg) + SUM_W'(s3_gx_reg) + SUM_W'(s3_gy_reg);

    always_comb
    begin
        if ((&sum[SUM_W-1:TEMP_W-1]) || !(|sum[SUM_W-1:TEMP_W-1]))
        begin
            sat = sum[TEMP_W-1:0];
        end
        else if (sum[SUM_W-1])
        begin
            sat = {1'b1, {(TEMP_W - 1){1'b0}}};
        end
        else
        begin
            sat = {1'b0, {(TEMP_W - 1){1'b1}}};
        end
    end

    assign above_temp = s3_tag_reg.calc ? sat : s3_t_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= in_vld;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            out_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_tag_reg   <= in_tag;
        s1_t_reg     <= center;
        s1_dv_reg    <= dv;
        s1_dh_reg    <= dh;

        s2_tag_reg   <= s1_tag_reg;
        s2_t_reg     <= s1_t_reg;
        s2_pxh_reg   <= pxh;
        s2_pxl_reg   <= pxl;
        s2_pyh_reg   <= pyh;
        s2_pyl_reg   <= pyl;

        s3_tag_reg   <= s2_tag_reg;
        s3_t_reg     <= s2_t_reg;
        s3_gx_reg    <= gx;
        s3_gy_reg    <= gy;

        out_pair_reg <= '{above_vld:  s3_tag_reg.above_vld,
                          self_vld:   s3_tag_reg.self_vld,
                          self_last:  s3_tag_reg.self_last,
                          row:        s3_tag_reg.row,
                          col:        s3_tag_reg.col,
                          above_temp: above_temp,
                          self_temp:  s3_tag_reg.self_temp};
    end

    assign out_vld  = out_vld_reg;
    assign out_pair = out_pair_reg;

endmodule

### tb/heat_ftcs_stencil_pass_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the FTCS five-point heat stencil pass core.
// Depends on hfsp_pkg and heat_ftcs_stencil_pass_core; streams grids in raster order
// and compares every result transfer with a cycle-free model of one diffusion step.
module heat_ftcs_stencil_pass_core_tb;
    import hfsp_pkg::*;

    localparam int     CLK_HALF      = 5;
    localparam int     RESET_CYCLES  = 7;
    // Results trail their input through the core's pipeline; cells of the first row
    // produce nothing, so this many quiet cycles are allowed before a register write
    // or the end of the run.
    localparam int     SETTLE_CYCLES = 16;
    // Cycles without any transfer on any channel before the run is declared hung.
    localparam int     QUIET_LIMIT   = 2000;
    localparam int     NUM_PHASES    = 12;
    localparam int     PHASE_ITEMS   = 32;
    localparam int     STORE_COLS    = 64;
    localparam int     REPORT_LIMIT  = 10;
    localparam longint TEMP_MAX      = 64'sd2147483647;
    localparam longint TEMP_MIN      = -64'sd2147483648;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;
    typedef enum int {TEMPS_SMOOTH, TEMPS_FULL, TEMPS_EDGE} temp_mix_e;

    // One complete set of the eight configuration registers.
    typedef struct {
        logic [COEF_W-1:0] coef_x;
        logic [COEF_W-1:0] coef_y;
        idx_t              rows_last;
        idx_t              cols_last;
        idx_t              hot_row_lo;
        idx_t              hot_row_hi;
        idx_t              hot_col_lo;
        idx_t              hot_col_hi;
    } grid_cfg_t;

    // One emitted cell as it should appear on the output port.
    typedef struct {
        temp_t temp;
        idx_t  row;
        idx_t  col;
        logic  last;
    } cell_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COEF_W-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    temp_t                temp_in;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    temp_t                temp_out;
    idx_t                 row_index;
    idx_t                 col_index;
    logic                 grid_last;

    // Model state: two banks of the line store (row parity selects the bank), the
    // left/center window, the raster position of the next cell and the live
    // register values, updated at the edge where each register write transfers.
    temp_t        line_mem [0:2*STORE_COLS-1];
    temp_t        win_left;
    temp_t        win_center;
    int           row_cnt;
    int           col_cnt;
    grid_cfg_t    live_cfg;
    cell_result_t expected_cells[$];

    int mismatch_count;
    int send_idle_pct;
    int stall_pct;
    int quiet_cycles = 0;

    heat_ftcs_stencil_pass_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .temp_in   (temp_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .temp_out  (temp_out),
        .row_index (row_index),
        .col_index (col_index),
        .grid_last (grid_last)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------
    // Next-step temperature model
    // ------------------------------------------------------------------

    function automatic int store_slot(int row, int col);
        return (row & 1) * STORE_COLS + (col % STORE_COLS);
    endfunction

    // floor(k * d / 2^32) for an unsigned Q0.32 gain. The full product needs up to
    // 67 bits, so it is formed at 72 bits and shifted arithmetically (which floors).
    function automatic longint scaled(logic [COEF_W-1:0] k, longint d);
        logic signed [71:0] kk;
        logic signed [71:0] dd;
        logic signed [71:0] prod;
        kk   = {40'd0, k};
        dd   = d;
        prod = (kk * dd) >>> 32;
        return prod[63:0];
    endfunction

    function automatic void push_result(temp_t t, int row, int col, logic last);
        expected_cells.push_back('{t, idx_t'(row), idx_t'(col), last});
    endfunction

    // Advances the model by one accepted input cell and queues the zero, one or two
    // results that it causes. The cell above is finished when the cell below it
    // arrives; a cell of the last row is also passed on as itself.
    function automatic void predict_cell_update(temp_t x);
        int     r;
        int     c;
        int     pr;
        temp_t  center;
        temp_t  result;
        longint n_up;
        longint n_left;
        longint n_right;
        longint mid;
        longint dv;
        longint dh;
        longint total;
        r = row_cnt;
        c = col_cnt;
        if (r >= 1)
        begin
            pr         = r - 1;
            center     = line_mem[store_slot(pr, c)];
            result     = center;
            win_left   = win_center;
            win_center = center;
            // Only interior cells outside the fixed-temperature window diffuse.
            if (pr >= 1 && pr < live_cfg.rows_last && c >= 1 && c < live_cfg.cols_last &&
                !(pr >= live_cfg.hot_row_lo && pr <= live_cfg.hot_row_hi &&
                  c >= live_cfg.hot_col_lo && c <= live_cfg.hot_col_hi))
            begin
                n_up    = line_mem[store_slot(r, c)];
                n_left  = win_left;
                n_right = line_mem[store_slot(pr, c + 1)];
                mid     = center;
                dv      = n_up + x - 2 * mid;
                dh      = n_left + n_right - 2 * mid;
                total   = mid + scaled(live_cfg.coef_x, dv) + scaled(live_cfg.coef_y, dh);
                if (total > TEMP_MAX)
                    result = temp_t'(TEMP_MAX);
                else if (total < TEMP_MIN)
                    result = temp_t'(TEMP_MIN);
                else
                    result = temp_t'(total);
            end
            push_result(result, pr, c, 1'b0);
        end

        line_mem[store_slot(r, c)] = x;

        if (r >= live_cfg.rows_last)
            push_result(x, r, c, c >= live_cfg.cols_last);

        // Positions beyond the configured size end the row or the grid.
        if (c >= live_cfg.cols_last)
        begin
            col_cnt = 0;
            row_cnt = (r >= live_cfg.rows_last) ? 0 : ((r + 1) & 63);
        end
        else
        begin
            col_cnt = (c + 1) & 63;
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checking: every output transfer is matched against the oldest
    // expectation. Outputs and out_stall are sampled at the edge, before any
    // nonblocking update of that edge lands.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cell_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_cells.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("Unexpected result: temp %0d row %0d col %0d last %0b",
                             temp_out, row_index, col_index, grid_last);
            end
            else
            begin
                want = expected_cells.pop_front();
                if (temp_out !== want.temp || row_index !== want.row ||
                    col_index !== want.col || grid_last !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("Mismatch: expected temp %0d row %0d col %0d last %0b, %s",
                                 want.temp, want.row, want.col, want.last,
                                 $sformatf("got temp %0d row %0d col %0d last %0b",
                                           temp_out, row_index, col_index, grid_last));
                end
            end
        end
    end

    // The receiver holds off output transfers at random when the phase asks for it.
    always @(posedge clk)
        out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);

    // Hang detection: any transfer on any channel restarts the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic set_idling(idle_mode_e mode);
        case (mode)
            IDLE_NONE:
            begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            IDLE_SENDER:
            begin
                send_idle_pct = 47;
                stall_pct     = 0;
            end
            IDLE_RECEIVER:
            begin
                send_idle_pct = 0;
                stall_pct     = 47;
            end
            default:
            begin
                send_idle_pct = 34;
                stall_pct     = 34;
            end
        endcase
    endtask

    // Drops the input valid and waits until every expected result has arrived,
    // then lets the pipeline run dry, since first-row cells leave no trace on the
    // output that could be waited for.
    task automatic wait_block_idle();
        in_valid <= 1'b0;
        while (expected_cells.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Presents one register write and holds it until it transfers. The valid is
    // left high so that back-to-back writes never lower and raise it in one step;
    // the caller lowers it after the last write.
    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [COEF_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (index)
            CFG_COEF_X:     live_cfg.coef_x     = value;
            CFG_COEF_Y:     live_cfg.coef_y     = value;
            CFG_ROWS_LAST:  live_cfg.rows_last  = value[IDX_W-1:0];
            CFG_COLS_LAST:  live_cfg.cols_last  = value[IDX_W-1:0];
            CFG_HOT_ROW_LO: live_cfg.hot_row_lo = value[IDX_W-1:0];
            CFG_HOT_ROW_HI: live_cfg.hot_row_hi = value[IDX_W-1:0];
            CFG_HOT_COL_LO: live_cfg.hot_col_lo = value[IDX_W-1:0];
            default:        live_cfg.hot_col_hi = value[IDX_W-1:0];
        endcase
    endtask

    task automatic apply_config(grid_cfg_t nc);
        wait_block_idle();
        write_reg(CFG_COEF_X, nc.coef_x);
        write_reg(CFG_COEF_Y, nc.coef_y);
        write_reg(CFG_ROWS_LAST, COEF_W'(nc.rows_last));
        write_reg(CFG_COLS_LAST, COEF_W'(nc.cols_last));
        write_reg(CFG_HOT_ROW_LO, COEF_W'(nc.hot_row_lo));
        write_reg(CFG_HOT_ROW_HI, COEF_W'(nc.hot_row_hi));
        write_reg(CFG_HOT_COL_LO, COEF_W'(nc.hot_col_lo));
        write_reg(CFG_HOT_COL_HI, COEF_W'(nc.hot_col_hi));
        cfg_valid <= 1'b0;
    endtask

    // Sends one cell and updates the model at the edge where it transfers. Gaps
    // are inserted before the cell, so the data never changes while stalled.
    task automatic send_cell(temp_t value);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        temp_in  <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_cell_update(value);
    endtask

    function automatic temp_t pick_temp(temp_mix_e mix);
        case (mix)
            // Realistic field: about +/-100 degrees in Q16.16.
            TEMPS_SMOOTH: return temp_t'(int'($urandom_range(13107200)) - 6553600);
            TEMPS_FULL:   return temp_t'($urandom);
            default:
            begin
                case ($urandom_range(7))
                    0:       return temp_t'(TEMP_MIN);
                    1:       return temp_t'(TEMP_MAX);
                    2:       return temp_t'(0);
                    3:       return temp_t'(-1);
                    default: return temp_t'($urandom);
                endcase
            end
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] pick_coef();
        case ($urandom_range(3))
            0:       return $urandom_range(32'h4000_0000);
            1:       return $urandom;
            2:       return 32'hFFFF_FFFF;
            default: return $urandom_range(255);
        endcase
    endfunction

    // One complete grid at the live size; reports how many cells it took.
    task automatic send_pass(temp_mix_e mix, output int count);
        count = (int'(live_cfg.rows_last) + 1) * (int'(live_cfg.cols_last) + 1);
        repeat (count) send_cell(pick_temp(mix));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Runs on the reset configuration (51 x 51 grid, default gains) and cuts the
    // grid short by shrinking its size mid-pass: the column counter is then past
    // the last column, which must end the row, and later the row counter is past
    // the last row, which must make that row the final one and wrap to zero.
    task automatic test_reset_defaults();
        set_idling(IDLE_NONE);
        repeat (4) send_cell(pick_temp(TEMPS_SMOOTH));
        wait_block_idle();
        write_reg(CFG_COLS_LAST, COEF_W'(2));
        cfg_valid <= 1'b0;
        // The fifth cell of row zero closes the row; rows one and two follow at
        // three cells each, so the one interior cell uses the default gains.
        repeat (7) send_cell(pick_temp(TEMPS_SMOOTH));
        wait_block_idle();
        write_reg(CFG_ROWS_LAST, COEF_W'(2));
        cfg_valid <= 1'b0;
        repeat (3) send_cell(pick_temp(TEMPS_SMOOTH));
    endtask

    // With both last indexes at zero every cell is a whole grid and leaves unchanged.
    task automatic test_degenerate_sizes();
        grid_cfg_t nc;
        nc = '{pick_coef(), pick_coef(), 6'd0, 6'd0, 6'd0, 6'd63, 6'd0, 6'd63};
        apply_config(nc);
        set_idling(IDLE_BOTH);
        repeat (3) send_cell(pick_temp(TEMPS_EDGE));
    endtask

    // A 3 x 4 grid with full-scale gains and an empty window. The first interior
    // cell sits at the top of the range with all four neighbors at the bottom, the
    // second the other way round, so the sum clamps in both directions.
    task automatic test_saturation();
        grid_cfg_t nc;
        temp_t     cells [12];
        cells = '{temp_t'(0), temp_t'(TEMP_MIN), temp_t'(TEMP_MAX), temp_t'(-1),
                  temp_t'(TEMP_MIN), temp_t'(TEMP_MAX), temp_t'(TEMP_MIN), temp_t'(TEMP_MAX),
                  temp_t'(1), temp_t'(TEMP_MIN), temp_t'(TEMP_MAX), temp_t'(0)};
        nc = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd2, 6'd3, 6'd63, 6'd0, 6'd5, 6'd4};
        apply_config(nc);
        set_idling(IDLE_RECEIVER);
        foreach (cells[i])
            send_cell(cells[i]);
    endtask

    // Random phases of complete passes. Each phase picks new gains, a new size and
    // a new window, and cycles through the idling modes. Two phases reach the
    // largest row and column index while keeping the other dimension small.
    task automatic test_random_passes();
        grid_cfg_t nc;
        temp_mix_e mix;
        int        sent;
        int        pass_cells;
        int        kind;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            nc.coef_x = pick_coef();
            nc.coef_y = pick_coef();
            if (p == 3)
            begin
                nc.coef_x = '0;
                nc.coef_y = '0;
            end
            nc.rows_last = idx_t'($urandom_range(6, 2));
            nc.cols_last = idx_t'($urandom_range(8, 2));
            if (p == 2)
            begin
                nc.rows_last = 6'd63;
                nc.cols_last = 6'd2;
            end
            if (p == 5)
            begin
                nc.rows_last = 6'd2;
                nc.cols_last = 6'd63;
            end

            // Window kinds: empty, inside the grid, the whole grid, anywhere.
            kind = (p == 4 || p == 6) ? 1 : $urandom_range(3);
            case (kind)
                0:
                begin
                    nc.hot_row_lo = idx_t'($urandom_range(63, 1));
                    nc.hot_row_hi = idx_t'($urandom_range(nc.hot_row_lo - 1, 0));
                    nc.hot_col_lo = idx_t'($urandom_range(63));
                    nc.hot_col_hi = idx_t'($urandom_range(63));
                end
                1:
                begin
                    nc.hot_row_lo = idx_t'($urandom_range(nc.rows_last));
                    nc.hot_row_hi = idx_t'($urandom_range(nc.rows_last, nc.hot_row_lo));
                    nc.hot_col_lo = idx_t'($urandom_range(nc.cols_last));
                    nc.hot_col_hi = idx_t'($urandom_range(nc.cols_last, nc.hot_col_lo));
                end
                2:
                begin
                    nc.hot_row_lo = 6'd0;
                    nc.hot_row_hi = 6'd63;
                    nc.hot_col_lo = 6'd0;
                    nc.hot_col_hi = 6'd63;
                end
                default:
                begin
                    nc.hot_row_lo = idx_t'($urandom_range(63));
                    nc.hot_row_hi = idx_t'($urandom_range(63));
                    nc.hot_col_lo = idx_t'($urandom_range(63));
                    nc.hot_col_hi = idx_t'($urandom_range(63));
                end
            endcase

            apply_config(nc);
            set_idling(idle_mode_e'(p % 4));
            mix  = (p == 0) ? TEMPS_SMOOTH : temp_mix_e'($urandom_range(2));
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                send_pass(mix, pass_cells);
                sent += pass_cells;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        temp_in        = '0;
        mismatch_count = 0;
        send_idle_pct  = 0;
        stall_pct      = 0;
        row_cnt        = 0;
        col_cnt        = 0;
        win_left       = '0;
        win_center     = '0;
        live_cfg       = '{COEF_RESET, COEF_RESET, SIZE_RESET, SIZE_RESET,
                           HOT_LO_RESET, HOT_HI_RESET, HOT_LO_RESET, HOT_HI_RESET};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_degenerate_sizes();
        test_saturation();
        test_random_passes();

        // Every expected result must arrive; stray results during the final quiet
        // stretch are still caught by the checker.
        wait_block_idle();
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
